>>> rtl/sar_pkg.sv
package sar_pkg;

  // normalized vector components, squares and root
  localparam int NORM_BITS = 30;
  localparam int SQ_BITS   = 61;
  localparam int ROOT_BITS = 31;

  // cordic datapath and angle widths
  localparam int CW        = 34;
  localparam int ANG_BITS  = 32;
  localparam int TABLE_LEN = 24;

  // angle in 1/65536 of a hundredth of a degree
  localparam int ANGLE_RES_BITS = 30;
  localparam logic [ANGLE_RES_BITS-1:0] ANGLE_FULL = 30'd589824000;
  localparam logic [13:0] LIMIT_MAX = 14'd9000;

  // ramp arithmetic
  localparam int NUM_BITS = 31;
  localparam int DIV_N_BITS = 47;
  localparam int Q_BITS = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_SPACING   = 3'd0;
  localparam logic [2:0] CFG_SCALE     = 3'd1;
  localparam logic [2:0] CFG_ANGLE_MIN = 3'd2;
  localparam logic [2:0] CFG_ANGLE_MAX = 3'd3;
  localparam logic [2:0] CFG_RAMP_MODE = 3'd4;

  localparam logic [1:0] RAMP_RISING = 2'd1;

  // atan(2^-i) in 1/65536 hundredths of a degree
  localparam logic [ANGLE_RES_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
    30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507, 30'd23437865,
    30'd11730358, 30'd5866613, 30'd2933484, 30'd1466766, 30'd733385,
    30'd366693, 30'd183346, 30'd91673, 30'd45837, 30'd22918, 30'd11459,
    30'd5730, 30'd2865, 30'd1432, 30'd716, 30'd358, 30'd179, 30'd90, 30'd45
  };

  // flags that ride beside the ramp division
  typedef struct packed {
    logic force_res;
    logic force_one;
  } ramp_flags_t;

  // arithmetic shift that truncates toward zero
  function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                     input int s);
    logic [CW-1:0] mag;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    mag = mag >> s;
    return v[CW-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/sar_isqrt.sv
module sar_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           vld_in,
  input  logic [sar_pkg::SQ_BITS-1:0]    rad_in,
  input  logic [sar_pkg::NORM_BITS-1:0]  z_in,
  output logic                           vld_out,
  output logic [sar_pkg::ROOT_BITS-1:0]  root_out,
  output logic [sar_pkg::NORM_BITS-1:0]  z_out
);

  localparam int RB = sar_pkg::ROOT_BITS;
  localparam int SB = sar_pkg::SQ_BITS;

  logic [RB-1:0] vld_q;
  logic [SB-1:0] rem_q  [RB];
  logic [RB-1:0] root_q [RB];
  logic [sar_pkg::NORM_BITS-1:0] z_q [RB];
  logic [SB-1:0] rem_next  [RB];
  logic [RB-1:0] root_next [RB];

  // one result bit per stage, most significant first
  always_comb begin
    logic [SB-1:0] cur_rem;
    logic [RB-1:0] cur_root;
    logic [SB:0]   trial;
    for (int k = 0; k < RB; k++) begin
      cur_rem  = (k == 0) ? rad_in : rem_q[(k == 0) ? 0 : k - 1];
      cur_root = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k - 1];
      trial = ((SB + 1)'(cur_root) << (RB - k)) + ((SB + 1)'(1) << (2 * (RB - 1 - k)));
      if ({1'b0, cur_rem} >= trial) begin
        rem_next[k]  = cur_rem - trial[SB-1:0];
        root_next[k] = cur_root | (RB'(1) << (RB - 1 - k));
      end else begin
        rem_next[k]  = cur_rem;
        root_next[k] = cur_root;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[RB-2:0], vld_in};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RB; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        z_q[k]    <= (k == 0) ? z_in : z_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign vld_out  = vld_q[RB-1];
  assign root_out = root_q[RB-1];
  assign z_out    = z_q[RB-1];

endmodule

>>> rtl/sar_cordic.sv
module sar_cordic #(
  parameter int ITER = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                vld_in,
  input  logic [sar_pkg::NORM_BITS-1:0]       x_in,
  input  logic [sar_pkg::ROOT_BITS-1:0]       y_in,
  output logic                                vld_out,
  output logic signed [sar_pkg::ANG_BITS-1:0] ang_out
);

  localparam int CW = sar_pkg::CW;
  localparam int AB = sar_pkg::ANG_BITS;

  logic [ITER-1:0] vld_q;
  logic signed [CW-1:0] cx_q [ITER];
  logic signed [CW-1:0] cy_q [ITER];
  logic signed [AB-1:0] ang_q [ITER];
  logic signed [CW-1:0] cx_next [ITER];
  logic signed [CW-1:0] cy_next [ITER];
  logic signed [AB-1:0] ang_next [ITER];

  // one vectoring rotation per stage
  always_comb begin
    logic signed [CW-1:0] cx, cy, dx, dy;
    logic signed [AB-1:0] ang, step;
    for (int k = 0; k < ITER; k++) begin
      cx  = (k == 0) ? $signed(CW'(x_in)) : cx_q[(k == 0) ? 0 : k - 1];
      cy  = (k == 0) ? $signed(CW'(y_in)) : cy_q[(k == 0) ? 0 : k - 1];
      ang = (k == 0) ? '0 : ang_q[(k == 0) ? 0 : k - 1];
      dx  = sar_pkg::shr_trunc(cy, k);
      dy  = sar_pkg::shr_trunc(cx, k);
      step = $signed(AB'(sar_pkg::ATAN_TABLE[k]));
      if (cy > 0) begin
        cx_next[k]  = cx + dx;
        cy_next[k]  = cy - dy;
        ang_next[k] = ang + step;
      end else begin
        cx_next[k]  = cx - dx;
        cy_next[k]  = cy + dy;
        ang_next[k] = ang - step;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ITER-2:0], vld_in};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ITER; k++) begin
        cx_q[k]  <= cx_next[k];
        cy_q[k]  <= cy_next[k];
        ang_q[k] <= ang_next[k];
      end
    end
  end

  assign vld_out = vld_q[ITER-1];
  assign ang_out = ang_q[ITER-1];

endmodule

>>> rtl/sar_div.sv
module sar_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   vld_in,
  input  logic [sar_pkg::DIV_N_BITS-1:0]         num_in,
  input  logic [sar_pkg::ANGLE_RES_BITS-1:0]     den_in,
  input  sar_pkg::ramp_flags_t                   flags_in,
  output logic                                   vld_out,
  output logic [sar_pkg::Q_BITS-1:0]             q_out
);

  localparam int NB = sar_pkg::DIV_N_BITS;
  localparam int DB = sar_pkg::ANGLE_RES_BITS;
  localparam int QB = sar_pkg::Q_BITS;

  // saturation check stage
  logic                 vld_s;
  logic                 sat_s;
  logic [NB-1:0]        rem_s;
  logic [DB-1:0]        den_s;
  sar_pkg::ramp_flags_t flags_s;

  logic [QB-1:0]        vld_q;
  logic [NB-1:0]        rem_q   [QB];
  logic [QB-1:0]        quo_q   [QB];
  logic [DB-1:0]        den_q   [QB];
  logic                 sat_q   [QB];
  sar_pkg::ramp_flags_t flags_q [QB];
  logic [NB-1:0]        rem_next [QB];
  logic [QB-1:0]        quo_next [QB];

  logic vld_o;
  logic [QB-1:0] q_o;

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NB-1:0] cur_rem, trial;
    logic [QB-1:0] cur_quo;
    logic [DB-1:0] cur_den;
    for (int k = 0; k < QB; k++) begin
      cur_rem = (k == 0) ? rem_s : rem_q[(k == 0) ? 0 : k - 1];
      cur_quo = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k - 1];
      cur_den = (k == 0) ? den_s : den_q[(k == 0) ? 0 : k - 1];
      trial = NB'(cur_den) << (QB - 1 - k);
      if (cur_rem >= trial) begin
        rem_next[k] = cur_rem - trial;
        quo_next[k] = cur_quo | (QB'(1) << (QB - 1 - k));
      end else begin
        rem_next[k] = cur_rem;
        quo_next[k] = cur_quo;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= 1'b0;
      vld_q <= '0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld_s <= vld_in;
      vld_q <= {vld_q[QB-2:0], vld_s};
      vld_o <= vld_q[QB-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      sat_s   <= num_in >= (NB'(den_in) << QB);
      rem_s   <= num_in;
      den_s   <= den_in;
      flags_s <= flags_in;
      for (int k = 0; k < QB; k++) begin
        rem_q[k]   <= rem_next[k];
        quo_q[k]   <= quo_next[k];
        den_q[k]   <= (k == 0) ? den_s : den_q[(k == 0) ? 0 : k - 1];
        sat_q[k]   <= (k == 0) ? sat_s : sat_q[(k == 0) ? 0 : k - 1];
        flags_q[k] <= (k == 0) ? flags_s : flags_q[(k == 0) ? 0 : k - 1];
      end
      // final select of forced, saturated or divided value
      if (flags_q[QB-1].force_res) begin
        q_o <= flags_q[QB-1].force_one ? '1 : '0;
      end else if (sat_q[QB-1]) begin
        q_o <= '1;
      end else begin
        q_o <= quo_q[QB-1];
      end
    end
  end

  assign vld_out = vld_o;
  assign q_out   = q_o;

endmodule

>>> rtl/slope_angle_ramp.sv
// throughput: one request per cycle; the square root and cordic stages set most of the depth
// the whole pipeline holds while a result waits at the output
// reset clears all valid bits and loads the register defaults:
// spacing 256, scale 256, angle min 0, angle max 9000, falling ramp
module slope_angle_ramp #(
  parameter int SAMPLE_BITS      = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // sample_down, sample_left, sample_right, sample_up
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ramp_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int W   = SAMPLE_BITS + 17;
  localparam int NB  = sar_pkg::NORM_BITS;
  localparam int SHW = $clog2(W + 1);
  localparam int AR  = sar_pkg::ANGLE_RES_BITS;
  localparam int NUB = sar_pkg::NUM_BITS;
  localparam int DNB = sar_pkg::DIV_N_BITS;

  logic        en;
  logic [15:0] query_spacing;
  logic [15:0] height_scale;
  logic [13:0] angle_min;
  logic [13:0] angle_max;
  logic [1:0]  ramp_mode;

  logic vld_a, vld_b, vld_c, vld_d, vld_e, vld_f, vld_g, vld_h, vld_i;
  logic [SB-1:0] adx_a, ady_a;
  logic [W-1:0]  ax_b, ay_b, z_b;
  logic [W-1:0]  ax_c, ay_c, z_c;
  logic [SHW-1:0] sh_c;
  logic [NB-1:0] ax_d, ay_d, z_d;
  logic [2*NB-1:0] sqx_e, sqy_e;
  logic [NB-1:0] z_e, z_f;
  logic [sar_pkg::SQ_BITS-1:0] rad_f;
  logic vld_s;
  logic [sar_pkg::ROOT_BITS-1:0] root_s;
  logic [NB-1:0] z_s;
  logic vld_k;
  logic signed [sar_pkg::ANG_BITS-1:0] ang_k;
  logic [AR-1:0] ang_g;
  logic signed [NUB-1:0] num_h, den_h;
  logic step_h, over_h;
  logic [DNB-1:0] nn_i;
  logic [AR-1:0] dd_i;
  sar_pkg::ramp_flags_t flags_i;
  logic vld_o;
  logic [15:0] q_o;

  logic [SB-1:0] s_down, s_left, s_right, s_up;
  logic signed [SB:0] dxs, dys;
  logic [W-1:0] m_max;
  logic [SHW-1:0] sh_next;
  logic [13:0] lim_lo, lim_hi;
  logic [AR-1:0] lo, hi;
  logic rising;
  logic [NUB-2:0] n_abs, d_abs;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      query_spacing <= 16'd256;
      height_scale  <= 16'd256;
      angle_min     <= 14'd0;
      angle_max     <= 14'd9000;
      ramp_mode     <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sar_pkg::CFG_SPACING:   query_spacing <= cfg_data;
        sar_pkg::CFG_SCALE:     height_scale  <= cfg_data;
        sar_pkg::CFG_ANGLE_MIN: angle_min     <= cfg_data[13:0];
        sar_pkg::CFG_ANGLE_MAX: angle_max     <= cfg_data[13:0];
        sar_pkg::CFG_RAMP_MODE: ramp_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sample differences
  assign s_down  = SB'(s_tdata[15:0]);
  assign s_left  = SB'(s_tdata[31:16]);
  assign s_right = SB'(s_tdata[47:32]);
  assign s_up    = SB'(s_tdata[63:48]);
  assign dxs = $signed({1'b0, s_left}) - $signed({1'b0, s_right});
  assign dys = $signed({1'b0, s_down}) - $signed({1'b0, s_up});

  // leading one of the largest component
  always_comb begin
    m_max = ax_b;
    if (ay_b > m_max) m_max = ay_b;
    if (z_b > m_max) m_max = z_b;
    sh_next = SHW'(1);
    for (int k = 0; k < W; k++) begin
      if (m_max[k]) sh_next = SHW'(k + 1);
    end
  end

  // ramp limits
  assign lim_lo = (angle_min > sar_pkg::LIMIT_MAX) ? sar_pkg::LIMIT_MAX : angle_min;
  assign lim_hi = (angle_max > sar_pkg::LIMIT_MAX) ? sar_pkg::LIMIT_MAX : angle_max;
  assign lo     = {lim_lo, 16'd0};
  assign hi     = {lim_hi, 16'd0};
  assign rising = (ramp_mode == sar_pkg::RAMP_RISING);
  assign n_abs  = num_h[NUB-1] ? (NUB-1)'(-num_h) : num_h[NUB-2:0];
  assign d_abs  = den_h[NUB-1] ? (NUB-1)'(-den_h) : den_h[NUB-2:0];

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      {vld_a, vld_b, vld_c, vld_d, vld_e, vld_f, vld_g, vld_h, vld_i} <= '0;
    end else if (en) begin
      vld_a <= s_tvalid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
      vld_e <= vld_d;
      vld_f <= vld_e;
      vld_g <= vld_k;
      vld_h <= vld_g;
      vld_i <= vld_h;
    end
  end

  // front stages: differences, scaling, normalizing, squares and their sum
  always_ff @(posedge clk) begin
    if (en) begin
      adx_a <= dxs[SB] ? SB'(-dxs) : dxs[SB-1:0];
      ady_a <= dys[SB] ? SB'(-dys) : dys[SB-1:0];
      ax_b  <= W'(adx_a) * W'(height_scale);
      ay_b  <= W'(ady_a) * W'(height_scale);
      z_b   <= W'({query_spacing, 1'b0}) << SB;
      ax_c  <= ax_b;
      ay_c  <= ay_b;
      z_c   <= z_b;
      sh_c  <= sh_next;
      ax_d  <= NB'({ax_c, {NB{1'b0}}} >> sh_c);
      ay_d  <= NB'({ay_c, {NB{1'b0}}} >> sh_c);
      z_d   <= NB'({z_c, {NB{1'b0}}} >> sh_c);
      sqx_e <= (2*NB)'(ax_d) * (2*NB)'(ax_d);
      sqy_e <= (2*NB)'(ay_d) * (2*NB)'(ay_d);
      z_e   <= z_d;
      rad_f <= {1'b0, sqx_e} + {1'b0, sqy_e};
      z_f   <= z_e;
    end
  end

  sar_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld_f),
    .rad_in   (rad_f),
    .z_in     (z_f),
    .vld_out  (vld_s),
    .root_out (root_s),
    .z_out    (z_s)
  );

  sar_cordic #(
    .ITER (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vld_s),
    .x_in    (z_s),
    .y_in    (root_s),
    .vld_out (vld_k),
    .ang_out (ang_k)
  );

  // back stages: clamp, ramp terms, dividend
  always_ff @(posedge clk) begin
    if (en) begin
      if (ang_k < 0) begin
        ang_g <= '0;
      end else if (ang_k > $signed(sar_pkg::ANG_BITS'(sar_pkg::ANGLE_FULL))) begin
        ang_g <= sar_pkg::ANGLE_FULL;
      end else begin
        ang_g <= ang_k[AR-1:0];
      end
      step_h <= (lo == hi);
      over_h <= rising ? (ang_g > lo) : (ang_g < lo);
      if (rising) begin
        num_h <= $signed({1'b0, ang_g}) - $signed({1'b0, lo});
        den_h <= $signed({1'b0, hi}) - $signed({1'b0, lo});
      end else begin
        num_h <= $signed({1'b0, ang_g}) - $signed({1'b0, hi});
        den_h <= $signed({1'b0, lo}) - $signed({1'b0, hi});
      end
      flags_i.force_res <= step_h | (num_h == 0) | (num_h[NUB-1] != den_h[NUB-1]);
      flags_i.force_one <= step_h & over_h;
      nn_i <= (DNB'(n_abs) << 16) - DNB'(n_abs) + DNB'(d_abs >> 1);
      dd_i <= d_abs;
    end
  end

  sar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld_i),
    .num_in   (nn_i),
    .den_in   (dd_i),
    .flags_in (flags_i),
    .vld_out  (vld_o),
    .q_out    (q_o)
  );

  assign m_tvalid = vld_o;
  assign m_tdata  = q_o;

`ifndef NO_ASSERTIONS
  // normalizing puts the top bit of the largest component at bit 29
  a_norm: assert property (@(posedge clk) disable iff (rst)
    vld_d && (ax_d != 0 || ay_d != 0 || z_d != 0) |-> (ax_d[NB-1] || ay_d[NB-1] || z_d[NB-1]))
    else $error("normalized vector lost its leading one");

  // the clamped angle never passes ninety degrees
  a_ang: assert property (@(posedge clk) disable iff (rst)
    vld_g |-> ang_g <= sar_pkg::ANGLE_FULL)
    else $error("clamped angle out of range");

  // a true ramp never divides by zero
  a_den: assert property (@(posedge clk) disable iff (rst)
    vld_h && !step_h |-> den_h != 0)
    else $error("ramp span is zero outside step mode");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

>>> tb/sv/slope_angle_ramp_test.sv
`timescale 1ns / 1ps

module slope_angle_ramp_test;

  localparam int SLOPE_ITERS = 16;
  localparam int PIPE_WAIT = 100;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0] RAMP_FALLING = 2'd0;
  localparam logic [1:0] RAMP_ALT_TWO = 2'd2;
  localparam logic [1:0] RAMP_ALT_THREE = 2'd3;

  // expected ramp values and the register copy used to predict them
  class ramp_scoreboard;
    logic [15:0] spacing;
    logic [15:0] scale;
    logic [13:0] angle_lo;
    logic [13:0] angle_hi;
    logic [1:0] mode;
    logic [15:0] ramp_q[$];
    int errors;
    int checked;

    function new();
      spacing = 16'd256;
      scale = 16'd256;
      angle_lo = 14'd0;
      angle_hi = 14'd9000;
      mode = RAMP_FALLING;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        sar_pkg::CFG_SPACING: spacing = v;
        sar_pkg::CFG_SCALE: scale = v;
        sar_pkg::CFG_ANGLE_MIN: angle_lo = v[13:0];
        sar_pkg::CFG_ANGLE_MAX: angle_hi = v[13:0];
        sar_pkg::CFG_RAMP_MODE: mode = v[1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint trunc_shift(longint v, int s);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      mag = mag >> s;
      return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // slope angle via cordic vectoring after normalizing the vector
    function longint slope_of(longint unsigned ax, longint unsigned ay, longint unsigned z);
      longint unsigned m;
      longint cx;
      longint cy;
      longint ang;
      longint dx;
      longint dy;
      m = (ax > ay) ? ax : ay;
      if (z > m) m = z;
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin
        m = m >> 1; ax = ax >> 1; ay = ay >> 1; z = z >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1; ax = ax << 1; ay = ay << 1; z = z << 1;
      end
      cx = longint'(z);
      cy = longint'(int_root(ax * ax + ay * ay));
      ang = 0;
      for (int i = 0; i < SLOPE_ITERS && i < sar_pkg::TABLE_LEN; i++) begin
        dx = trunc_shift(cy, i);
        dy = trunc_shift(cx, i);
        if (cy > 0) begin
          cx = cx + dx; cy = cy - dy; ang = ang + longint'(sar_pkg::ATAN_TABLE[i]);
        end else begin
          cx = cx - dx; cy = cy + dy; ang = ang - longint'(sar_pkg::ATAN_TABLE[i]);
        end
      end
      if (ang < 0) ang = 0;
      if (ang > longint'(sar_pkg::ANGLE_FULL)) ang = longint'(sar_pkg::ANGLE_FULL);
      return ang;
    endfunction

    function logic [15:0] ramp_of(longint num, longint den);
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      if (num == 0 || ((num < 0) != (den < 0))) return 16'd0;
      n = (num < 0) ? longint'(-num) : longint'(num);
      d = (den < 0) ? longint'(-den) : longint'(den);
      q = (n * 65535 + d / 2) / d;
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function logic [15:0] predict_ramp(logic [63:0] d);
      longint dxs;
      longint dys;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned z;
      longint ang;
      longint lo;
      longint hi;
      logic rising;
      dxs = longint'(d[31:16]) - longint'(d[47:32]);
      dys = longint'(d[15:0]) - longint'(d[63:48]);
      ax = longint'((dxs < 0) ? -dxs : dxs) * longint'(scale);
      ay = longint'((dys < 0) ? -dys : dys) * longint'(scale);
      z = (longint'(spacing) * 2) << 16;
      ang = slope_of(ax, ay, z);
      lo = longint'((angle_lo > sar_pkg::LIMIT_MAX) ? sar_pkg::LIMIT_MAX : angle_lo) * 65536;
      hi = longint'((angle_hi > sar_pkg::LIMIT_MAX) ? sar_pkg::LIMIT_MAX : angle_hi) * 65536;
      rising = (mode == sar_pkg::RAMP_RISING);
      if (lo == hi) begin
        if (rising) return (ang > lo) ? 16'hFFFF : 16'd0;
        return (ang < lo) ? 16'hFFFF : 16'd0;
      end
      if (rising) return ramp_of(ang - lo, hi - lo);
      return ramp_of(ang - hi, lo - hi);
    endfunction

    function void note_request(logic [63:0] d);
      ramp_q.insert(ramp_q.size(), predict_ramp(d));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] v);
      logic [15:0] want;
      if (ramp_q.size() == 0) begin
        report($sformatf("unexpected ramp_value %0d", v));
      end else begin
        want = ramp_q.pop_front();
        checked++;
        if (v !== want) report($sformatf("ramp_value got %0d want %0d", v, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  ramp_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int sent;

  slope_angle_ramp i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check accepted results and stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one request, with random idle cycles ahead of it
  task send_samples(logic [15:0] down, logic [15:0] left, logic [15:0] right,
                    logic [15:0] up);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {up, right, left, down};
    do @(posedge clk); while (!s_tready);
    sb.note_request({up, right, left, down});
    sent++;
  endtask

  task wait_idle();
    s_tvalid <= 1'b0;
    while (sb.ramp_q.size() > 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task write_all(logic [15:0] sp, logic [15:0] sc, logic [13:0] lo, logic [13:0] hi,
                 logic [1:0] md);
    logic [2:0] idx [5];
    logic [15:0] val [5];
    idx = '{sar_pkg::CFG_SPACING, sar_pkg::CFG_SCALE, sar_pkg::CFG_ANGLE_MIN,
            sar_pkg::CFG_ANGLE_MAX, sar_pkg::CFG_RAMP_MODE};
    val = '{sp, sc, {2'b00, lo}, {2'b00, hi}, {14'd0, md}};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly smooth patches around a random height, some raw noise
  task send_random();
    logic [15:0] c;
    int w;
    if ($urandom_range(0, 3) == 0) begin
      send_samples(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if ($urandom_range(0, 9) == 0) begin
      c = 16'($urandom);
      send_samples(c, c, c, c);
    end else begin
      c = 16'($urandom_range(16384, 49151));
      w = int'($urandom_range(0, 13));
      send_samples(16'(c + ($urandom % (1 << w))), 16'(c + ($urandom % (1 << w))),
                   16'(c - ($urandom % (1 << w))), 16'(c - ($urandom % (1 << w))));
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    send_idle_pct = 36;
    recv_idle_pct = 62;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= sar_pkg::CFG_SPACING;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flat, steepest, single-axis slopes at reset settings
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_samples(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_samples(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_samples(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_samples(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    send_samples(16'h8000, 16'h8001, 16'h8000, 16'h8000);
    send_samples(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_samples(16'h0200, 16'h0200, 16'h0000, 16'h0000);
    wait_idle();

    // an unused register index must leave everything alone
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);

    // zero spacing: any slope is vertical, flat is zero angle
    write_all(16'd0, 16'd256, 14'd0, 14'd9000, sar_pkg::RAMP_RISING);
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h1234, 16'h1234, 16'h1234, 16'h1234);
    send_samples(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_samples(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    wait_idle();
    // equal limits give a step, both directions
    write_all(16'd256, 16'd256, 14'd4500, 14'd4500, sar_pkg::RAMP_RISING);
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    wait_idle();
    write_all(16'd256, 16'd256, 14'd4500, 14'd4500, RAMP_ALT_THREE);
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    wait_idle();

    // random phases over a spread of register settings
    for (int k = 0; k < 8; k++) begin
      if (k == 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 36;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k)
        0: write_all(16'd256, 16'd256, 14'd0, 14'd9000, RAMP_FALLING);
        1: write_all(16'd1, 16'd65535, 14'd1000, 14'd8000, sar_pkg::RAMP_RISING);
        2: write_all(16'd65535, 16'd65535, 14'd9000, 14'd0, RAMP_ALT_TWO);
        3: write_all(16'd0, 16'd0, 14'd16383, 14'd2000, sar_pkg::RAMP_RISING);
        4: write_all(16'd40, 16'd300, 14'd3000, 14'd3000, RAMP_FALLING);
        5: write_all(16'd512, 16'd128, 14'd12000, 14'd16383, RAMP_ALT_THREE);
        6: write_all(16'($urandom), 16'($urandom), 14'($urandom_range(0, 9000)),
                     14'($urandom_range(0, 9000)), sar_pkg::RAMP_RISING);
        default: write_all(16'($urandom), 16'($urandom), 14'($urandom), 14'($urandom),
                           2'($urandom));
      endcase
      for (int n = 0; n < 85; n++) send_random();
      wait_idle();
    end

    $display("covered %0d requests, %0d results checked, eight register settings",
             sent, sb.checked);
    $display("settings included zero spacing, equal, reversed and clamped limits, all ramp codes");
    if (sb.errors == 0 && sb.ramp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
